[design/ttr_pkg.sv]
// Shared types and constants of the transposition table block.
`default_nettype none

package ttr_pkg;

    typedef enum logic [1:0] {
        FUNC_PROBE = 2'd0,
        FUNC_STORE = 2'd1,
        FUNC_NEW_SEARCH = 2'd2,
        FUNC_CLEAR = 2'd3
    } ttr_func_t;

    localparam int KEY_W = 64;
    localparam int MOVE_W = 16;
    localparam int SCORE_W = 16;
    localparam int DEPTH_W = 8;
    localparam int BOUND_W = 2;
    localparam int PLY_W = 8;
    localparam int AGE_W = 8;

    localparam int PAYLOAD_W = MOVE_W + SCORE_W + DEPTH_W + BOUND_W + AGE_W;
    localparam int ENTRY_W = KEY_W + PAYLOAD_W;

    localparam int S_TDATA_W = 120;
    localparam int M_TDATA_W = 56;

    localparam logic signed [17:0] MATE_EDGE = 18'sd29000;
    localparam logic signed [17:0] SCORE_MAX = 18'sd32767;
    localparam logic signed [17:0] SCORE_MIN = -18'sd32768;

    typedef struct packed {
        logic read_en;
        logic commit;
        logic sweep;
    } ttr_cmd_t;

    typedef struct packed {
        logic out_free;
        logic sweep_last;
    } ttr_sts_t;

endpackage

`default_nettype wire

[design/transposition_table_replace_top.sv]
// Top level of the direct-mapped transposition table with replacement rule.
//
// Requests arrive on the s_ stream: s_tuser carries the operation (probe, store,
// new search, clear) and s_tdata the key, move, score, depth, bound and ply.
// Every request yields exactly one result on the m_ stream; m_tuser is the hit
// flag and m_tdata the stored fields, all zero unless a probe hits.
// A probe, store or new search reads the entry from the single-port table in
// the cycle of acceptance and writes it back, if at all, when the result is
// registered, which waits until the output register is free. One request is in
// flight at a time; a new one is accepted only after the last is committed.
// A clear sweeps the table one entry per cycle and then yields its result.
// After reset the same sweep runs with s_tready low.
// A request may be accepted while the previous result still waits on a stalled
// receiver; its result is held back until the output register is free.
`default_nettype none

module transposition_table_replace_top #(
    parameter int ENTRIES = 65536
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    // hash_key, best_move, eval_score, search_depth, bound_kind, ply_from_root
    input  wire logic [ttr_pkg::S_TDATA_W-1:0] s_tdata,
    // func
    input  wire logic [1:0]                    s_tuser,
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    // found_move, found_score, found_depth, found_bound, found_age
    output logic [ttr_pkg::M_TDATA_W-1:0]      m_tdata,
    // hit
    output logic [0:0]                         m_tuser
);

    ttr_pkg::ttr_cmd_t cmd;
    ttr_pkg::ttr_sts_t sts;

    ttr_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tuser  (s_tuser),
        .s_tready (s_tready),
        .cmd      (cmd),
        .sts      (sts)
    );

    ttr_dp #(
        .ENTRIES (ENTRIES)
    ) u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .cmd      (cmd),
        .sts      (sts),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    a_no_accept_in_sweep: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.sweep |-> !s_tready)
        else $error("Request accepted during a table sweep.");

    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("Second request accepted before the first completed.");

    a_commit_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.commit |-> sts.out_free)
        else $error("Result committed over an unsent result.");

    a_commit_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.commit |=> m_tvalid)
        else $error("Committed result not presented.");

endmodule

`default_nettype wire

[design/ttr_ctrl.sv]
// Controller state machine of the transposition table block.
`default_nettype none

module ttr_ctrl (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             s_tvalid,
    input  wire logic [1:0]       s_tuser,
    output logic                  s_tready,
    output ttr_pkg::ttr_cmd_t     cmd,
    input  wire ttr_pkg::ttr_sts_t sts
);

    typedef enum logic [1:0] {
        ST_INIT,
        ST_IDLE,
        ST_EXEC,
        ST_WIPE
    } state_t;

    state_t state_reg, state_next;
    logic   ready_reg, ready_next;
    logic   accept;

    assign s_tready = ready_reg;
    assign accept = ready_reg & s_tvalid;

    assign cmd.read_en = accept;
    assign cmd.commit = (state_reg == ST_EXEC) & sts.out_free;
    assign cmd.sweep = (state_reg == ST_INIT) | (state_reg == ST_WIPE);

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_INIT: begin
                if (sts.sweep_last) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (accept) begin
                    if (ttr_pkg::ttr_func_t'(s_tuser) == ttr_pkg::FUNC_CLEAR) begin
                        state_next = ST_WIPE;
                    end else begin
                        state_next = ST_EXEC;
                    end
                end
            end
            ST_EXEC: begin
                if (sts.out_free) begin
                    state_next = ST_IDLE;
                end
            end
            ST_WIPE: begin
                if (sts.sweep_last) begin
                    state_next = ST_EXEC;
                end
            end
            default: state_next = ST_INIT;
        endcase
        ready_next = (state_next == ST_IDLE);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_INIT;
            ready_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            ready_reg <= ready_next;
        end
    end

endmodule

`default_nettype wire

[design/ttr_dp.sv]
// Datapath of the transposition table block: entry memory, replacement and result register.
`default_nettype none

module ttr_dp #(
    parameter int ENTRIES = 65536
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic [ttr_pkg::S_TDATA_W-1:0]   s_tdata,
    input  wire logic [1:0]                      s_tuser,
    input  wire ttr_pkg::ttr_cmd_t               cmd,
    output ttr_pkg::ttr_sts_t                    sts,
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    output logic [ttr_pkg::M_TDATA_W-1:0]        m_tdata,
    output logic [0:0]                           m_tuser
);

    localparam int IDX_W = $clog2(ENTRIES);

    logic [ttr_pkg::ENTRY_W-1:0] mem [ENTRIES];

    ttr_pkg::ttr_func_t                func_reg;
    logic [ttr_pkg::KEY_W-1:0]         key_reg;
    logic [ttr_pkg::MOVE_W-1:0]        move_reg;
    logic signed [ttr_pkg::SCORE_W-1:0] score_reg;
    logic signed [ttr_pkg::DEPTH_W-1:0] depth_reg;
    logic [ttr_pkg::BOUND_W-1:0]       bound_reg;
    logic [ttr_pkg::PLY_W-1:0]         ply_reg;

    logic [ttr_pkg::ENTRY_W-1:0]       rd_reg;
    logic [ttr_pkg::AGE_W-1:0]         gen_reg, gen_next;
    logic [IDX_W-1:0]                  sweep_cnt_reg, sweep_cnt_next;
    logic                              m_tvalid_reg, m_tvalid_next;
    logic [ttr_pkg::M_TDATA_W-1:0]     m_tdata_reg;
    logic                              hit_reg;

    logic [ttr_pkg::KEY_W-1:0]         rd_key;
    logic [ttr_pkg::MOVE_W-1:0]        rd_move;
    logic [ttr_pkg::SCORE_W-1:0]       rd_score;
    logic signed [ttr_pkg::DEPTH_W-1:0] rd_depth;
    logic [ttr_pkg::BOUND_W-1:0]       rd_bound;
    logic [ttr_pkg::AGE_W-1:0]         rd_age;

    logic signed [17:0]                score_ext;
    logic signed [17:0]                score_adj;
    logic [ttr_pkg::SCORE_W-1:0]       score_sat;
    logic                              key_match;
    logic                              replace;
    logic [ttr_pkg::MOVE_W-1:0]        move_wr;
    logic                              we;
    logic [IDX_W-1:0]                  waddr;
    logic [ttr_pkg::ENTRY_W-1:0]       wdata;
    logic                              probe_hit;
    logic [ttr_pkg::M_TDATA_W-1:0]     result;

    assign {rd_key, rd_move, rd_score, rd_depth, rd_bound, rd_age} = rd_reg;

    always_comb begin
        score_ext = {{2{score_reg[ttr_pkg::SCORE_W-1]}}, score_reg};
        priority if (score_ext > ttr_pkg::MATE_EDGE) begin
            score_adj = score_ext + $signed({10'd0, ply_reg});
        end else if (score_ext < -ttr_pkg::MATE_EDGE) begin
            score_adj = score_ext - $signed({10'd0, ply_reg});
        end else begin
            score_adj = score_ext;
        end
        priority if (score_adj > ttr_pkg::SCORE_MAX) begin
            score_sat = 16'h7fff;
        end else if (score_adj < ttr_pkg::SCORE_MIN) begin
            score_sat = 16'h8000;
        end else begin
            score_sat = score_adj[ttr_pkg::SCORE_W-1:0];
        end

        key_match = (rd_key == key_reg);
        replace = !key_match || (depth_reg >= rd_depth) || (rd_age != gen_reg);
        move_wr = (move_reg == '0) ? rd_move : move_reg;

        probe_hit = (func_reg == ttr_pkg::FUNC_PROBE) && key_match;
        result = '0;
        if (probe_hit) begin
            result = {6'd0, rd_age, rd_bound, rd_depth, rd_score, rd_move};
        end

        if (cmd.sweep) begin
            we = 1'b1;
            waddr = sweep_cnt_reg;
            wdata = '0;
        end else begin
            we = cmd.commit && (func_reg == ttr_pkg::FUNC_STORE) && replace;
            waddr = key_reg[IDX_W-1:0];
            wdata = {key_reg, move_wr, score_sat, depth_reg, bound_reg, gen_reg};
        end

        gen_next = gen_reg;
        if (cmd.sweep) begin
            gen_next = '0;
        end else if (cmd.commit && (func_reg == ttr_pkg::FUNC_NEW_SEARCH)) begin
            gen_next = gen_reg + 8'd1;
        end

        sweep_cnt_next = cmd.sweep ? sweep_cnt_reg + IDX_W'(1) : sweep_cnt_reg;

        m_tvalid_next = m_tvalid_reg;
        if (cmd.commit) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    assign sts.out_free = !m_tvalid_reg || m_tready;
    assign sts.sweep_last = (sweep_cnt_reg == '1);

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata = m_tdata_reg;
    assign m_tuser = hit_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (cmd.read_en) begin
            rd_reg <= mem[s_tdata[IDX_W-1:0]];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.read_en) begin
            func_reg <= ttr_pkg::ttr_func_t'(s_tuser);
            key_reg <= s_tdata[63:0];
            move_reg <= s_tdata[79:64];
            score_reg <= s_tdata[95:80];
            depth_reg <= s_tdata[103:96];
            bound_reg <= s_tdata[105:104];
            ply_reg <= s_tdata[113:106];
        end
        if (cmd.commit) begin
            m_tdata_reg <= result;
            hit_reg <= probe_hit;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gen_reg <= '0;
            sweep_cnt_reg <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            gen_reg <= gen_next;
            sweep_cnt_reg <= sweep_cnt_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

endmodule

`default_nettype wire
